[src/fftc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fftc_pkg
// Shared types, constants and twiddle ROM for the FFT convolution block.
// ----------------------------------------------------------------------------
package fftc_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WORK_BITS_DEF   = 40;
    localparam int IN_BITS         = 16;
    localparam int COEF_BITS       = 16;
    localparam int LOG_BITS        = 3;
    localparam int LOG_RESET       = 6;
    localparam int TW_BITS         = 17;

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_SWAP  = 3'd2;
    localparam logic [2:0] OP_BFLY  = 3'd3;
    localparam logic [2:0] OP_BIN   = 3'd4;
    localparam logic [2:0] OP_OUT   = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] addr_a;
        logic [5:0] addr_b;
        logic [4:0] tw_idx;   // ROM index t = m*stride (mod 32)
        logic       inverse;
        logic [2:0] bits;
        logic       last;
    } t_cmd;

    localparam logic [15:0] QSIN [17] = '{
        16'd0, 16'd3212, 16'd6393, 16'd9512, 16'd12540, 16'd15447, 16'd18205,
        16'd20788, 16'd23170, 16'd25330, 16'd27246, 16'd28899, 16'd30274,
        16'd31357, 16'd32138, 16'd32610, 16'd32767
    };

    function automatic logic signed [TW_BITS-1:0] rom_sin(input logic [4:0] t);
        logic [4:0] k;
        k = (t <= 5'd16) ? t : 5'd0 - t;
        return $signed({1'b0, QSIN[k]});
    endfunction

    function automatic logic signed [TW_BITS-1:0] rom_cos(input logic [4:0] t);
        logic [4:0] k;
        logic signed [TW_BITS-1:0] v;
        if (t <= 5'd16) begin
            k = 5'd16 - t;
            v = $signed({1'b0, QSIN[k]});
        end else begin
            k = t - 5'd16;
            v = -$signed({1'b0, QSIN[k]});
        end
        return v;
    endfunction

endpackage

[src/fft_circular_convolution.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_circular_convolution
// Block circular convolution through forward FFT, bin multiply, inverse FFT.
// ----------------------------------------------------------------------------
// Loads N = 2^log2_points samples, at most one per cycle, each with its bin
// response. After the last sample, input stalls while one shared four-stage
// butterfly unit runs bit reversal and a drain before each of two transforms
// of N/2*log2(N) butterflies (each butterfly waits for its write-back), N bin
// products between the transforms and N outputs after them; outputs are held
// back while the result side stalls. Writing log2_points restarts loading.
module fft_circular_convolution #(
    parameter int MAX_POINTS  = fftc_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = fftc_pkg::SAMPLE_BITS_DEF,
    parameter int WORK_BITS   = fftc_pkg::WORK_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fftc_pkg::LOG_BITS-1:0]         i_cfg_wdata,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [fftc_pkg::IN_BITS-1:0]   i_sample_in,
    input  logic signed [fftc_pkg::COEF_BITS-1:0] i_resp_real,
    input  logic signed [fftc_pkg::COEF_BITS-1:0] i_resp_imag,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_out,
    output logic                                  o_is_last,
    output logic                                  o_clipped
);
    fftc_pkg::t_cmd cmd;
    logic dp_busy, room, rv, rl, rc;
    logic signed [SAMPLE_BITS-1:0] rd;

    fftc_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_valid, .o_stall,
        .i_dp_busy(dp_busy), .i_out_room(room), .o_cmd(cmd)
    );

    fftc_dp #(
        .MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS), .WORK_BITS(WORK_BITS)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_sample(i_sample_in),
        .i_resp_real, .i_resp_imag, .o_busy(dp_busy),
        .o_res_valid(rv), .o_res_data(rd), .o_res_last(rl), .o_res_clip(rc)
    );

    fftc_ofifo #(.SAMPLE_BITS(SAMPLE_BITS)) u_ofifo (
        .i_clk, .i_rst_n, .i_wr(rv), .i_data(rd), .i_last(rl), .i_clip(rc),
        .o_room(room), .o_valid, .i_stall, .o_data(o_sample_out),
        .o_last(o_is_last), .o_clip(o_clipped)
    );
endmodule

[src/fftc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fftc_ctrl
// Sequencer: loading, bit reversal, butterfly passes, bin products, output.
// ----------------------------------------------------------------------------
module fftc_ctrl #(
    parameter int MAX_POINTS = fftc_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fftc_pkg::LOG_BITS-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_dp_busy,   // datapath has ops in flight
    input  logic                          i_out_room,  // output FIFO can take one more
    output fftc_pkg::t_cmd                o_cmd
);
    localparam int TOP = $clog2(MAX_POINTS);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_REV  = 3'd1;
    localparam logic [2:0] S_BF   = 3'd2;
    localparam logic [2:0] S_BIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_next, n_next;      // state after the drain wait
    logic [2:0] r_log, n_log;
    logic [6:0] r_cnt, n_cnt;        // load / element counter
    logic [2:0] r_stage, n_stage;    // butterfly pass (log2 of half)
    logic [5:0] r_bidx, n_bidx;      // butterfly number in the pass
    logic       r_inv, n_inv;
    logic [2:0] bits;
    logic [6:0] npts;
    logic [5:0] rev;
    logic [5:0] half, j, k, mm;
    logic [5:0] lowmask;
    logic [4:0] tw;

    always_comb begin
        bits = r_log;
        if (bits < 3'd1) bits = 3'd1;
        if (bits > 3'(TOP)) bits = 3'(TOP);
    end
    assign npts = 7'd1 << bits;

    always_comb begin
        rev = '0;
        for (int b = 0; b < 6; b++) begin
            if (b < int'(bits)) rev[int'(bits) - 1 - b] = r_cnt[b];
        end
    end

    // butterfly b in pass s: m = b mod half, j = (b/half)*2*half + m
    always_comb begin
        half    = 6'd1 << r_stage;
        lowmask = half - 6'd1;
        mm      = r_bidx & lowmask;
        j       = ((r_bidx & ~lowmask) << 1) | mm;
        k       = j | half;
        tw      = 5'((mm << (3'd5 - r_stage)) & 6'h1f);
    end

    // a register write takes the load slot, so no request is taken with it
    assign o_stall = (r_state != S_LOAD) || i_cfg_we;

    always_comb begin
        n_state = r_state;
        n_next  = r_next;
        n_log   = r_log;
        n_cnt   = r_cnt;
        n_stage = r_stage;
        n_bidx  = r_bidx;
        n_inv   = r_inv;
        o_cmd   = '0;
        o_cmd.bits    = bits;
        o_cmd.inverse = r_inv;
        case (r_state)
            S_LOAD: begin
                o_cmd.addr_a = r_cnt[5:0];
                if (i_cfg_we) begin
                    n_log = i_cfg_wdata;
                    n_cnt = '0;
                end else if (i_valid) begin
                    o_cmd.op = fftc_pkg::OP_LOAD;
                    if (r_cnt + 7'd1 >= npts) begin
                        n_cnt   = '0;
                        n_inv   = 1'b0;
                        n_state = S_WAIT;
                        n_next  = S_REV;
                    end else begin
                        n_cnt = r_cnt + 7'd1;
                    end
                end
            end
            S_REV: begin
                o_cmd.addr_a = r_cnt[5:0];
                o_cmd.addr_b = rev;
                if (r_cnt[5:0] < rev) o_cmd.op = fftc_pkg::OP_SWAP;
                if (r_cnt + 7'd1 >= npts) begin
                    n_cnt   = '0;
                    n_stage = '0;
                    n_bidx  = '0;
                    n_state = S_WAIT;
                    n_next  = S_BF;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_BF: begin
                // one butterfly issued, then wait for its write-back
                o_cmd.op     = fftc_pkg::OP_BFLY;
                o_cmd.addr_a = j;
                o_cmd.addr_b = k;
                o_cmd.tw_idx = tw;
                n_state      = S_WAIT;
                n_next       = S_BF;
                if ({1'b0, r_bidx} + 7'd1 >= (npts >> 1)) begin
                    n_bidx = '0;
                    if (r_stage + 3'd1 >= bits) begin
                        n_stage = '0;
                        n_next  = r_inv ? S_OUT : S_BIN;
                    end else begin
                        n_stage = r_stage + 3'd1;
                    end
                end else begin
                    n_bidx = r_bidx + 6'd1;
                end
            end
            S_BIN: begin
                o_cmd.op     = fftc_pkg::OP_BIN;
                o_cmd.addr_a = r_cnt[5:0];
                n_state      = S_WAIT;
                n_next       = S_BIN;
                if (r_cnt + 7'd1 >= npts) begin
                    n_cnt  = '0;
                    n_inv  = 1'b1;
                    n_next = S_REV;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_OUT: begin
                o_cmd.addr_a = r_cnt[5:0];
                if (i_out_room) begin
                    o_cmd.op   = fftc_pkg::OP_OUT;
                    o_cmd.last = (r_cnt + 7'd1 >= npts);
                    n_state    = S_WAIT;
                    n_next     = S_OUT;
                    if (r_cnt + 7'd1 >= npts) begin
                        n_cnt  = '0;
                        n_inv  = 1'b0;
                        n_next = S_LOAD;
                    end else begin
                        n_cnt = r_cnt + 7'd1;
                    end
                end
            end
            S_WAIT: begin
                if (!i_dp_busy) n_state = r_next;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_next  <= S_LOAD;
            r_log   <= 3'(fftc_pkg::LOG_RESET);
            r_cnt   <= '0;
            r_stage <= '0;
            r_bidx  <= '0;
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_next  <= n_next;
            r_log   <= n_log;
            r_cnt   <= n_cnt;
            r_stage <= n_stage;
            r_bidx  <= n_bidx;
            r_inv   <= n_inv;
        end
    end
endmodule

[src/fftc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fftc_dp
// Working memories, shared butterfly / bin multiplier, output rounding.
// ----------------------------------------------------------------------------
module fftc_dp #(
    parameter int MAX_POINTS  = fftc_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = fftc_pkg::SAMPLE_BITS_DEF,
    parameter int WORK_BITS   = fftc_pkg::WORK_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fftc_pkg::t_cmd                      i_cmd,
    input  logic signed [fftc_pkg::IN_BITS-1:0] i_sample,
    input  logic signed [fftc_pkg::COEF_BITS-1:0] i_resp_real,
    input  logic signed [fftc_pkg::COEF_BITS-1:0] i_resp_imag,
    output logic                                o_busy,
    output logic                                o_res_valid,
    output logic signed [SAMPLE_BITS-1:0]       o_res_data,
    output logic                                o_res_last,
    output logic                                o_res_clip
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SW = WORK_BITS + 18 + 2;  // sum of two products

    logic signed [WORK_BITS-1:0] mem_re [MAX_POINTS];
    logic signed [WORK_BITS-1:0] mem_im [MAX_POINTS];
    logic signed [fftc_pkg::COEF_BITS-1:0] coef_re [MAX_POINTS];
    logic signed [fftc_pkg::COEF_BITS-1:0] coef_im [MAX_POINTS];

    // pipeline: p1 read, p2 multiply, p3 round+sum, p4 write back
    logic [2:0] r_p1_op, r_p2_op, r_p3_op;
    logic [AW-1:0] r_p1_a, r_p1_b, r_p2_a, r_p2_b, r_p3_a, r_p3_b;
    logic [2:0] r_p1_bits, r_p2_bits;
    logic r_p1_last, r_p2_last;
    logic signed [WORK_BITS-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [WORK_BITS-1:0] r2_ar, r2_ai, r2_br, r2_bi;
    logic signed [fftc_pkg::COEF_BITS-1:0] r_cr, r_ci;
    logic signed [fftc_pkg::TW_BITS-1:0] r_wr, r_wi;
    logic signed [WORK_BITS+fftc_pkg::TW_BITS-1:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [WORK_BITS-1:0] r_xr, r_xi, r_yr, r_yi;

    assign o_busy = (r_p1_op != fftc_pkg::OP_NONE) || (r_p2_op != fftc_pkg::OP_NONE)
                    || (r_p3_op != fftc_pkg::OP_NONE);

    function automatic logic signed [WORK_BITS-1:0] sat(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] hi, lo;
        hi = SW'({1'b0, {(WORK_BITS-1){1'b1}}});
        lo = -hi - SW'(1);
        if (x > hi) return hi[WORK_BITS-1:0];
        if (x < lo) return lo[WORK_BITS-1:0];
        return x[WORK_BITS-1:0];
    endfunction

    // stage 1: memory read, plus the load and write-back writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == fftc_pkg::OP_LOAD) begin
            mem_re[i_cmd.addr_a[AW-1:0]]  <= WORK_BITS'(i_sample);
            mem_im[i_cmd.addr_a[AW-1:0]]  <= '0;
            coef_re[i_cmd.addr_a[AW-1:0]] <= i_resp_real;
            coef_im[i_cmd.addr_a[AW-1:0]] <= i_resp_imag;
        end else if (r_p3_op == fftc_pkg::OP_SWAP || r_p3_op == fftc_pkg::OP_BFLY) begin
            mem_re[r_p3_a] <= r_xr;
            mem_im[r_p3_a] <= r_xi;
            mem_re[r_p3_b] <= r_yr;
            mem_im[r_p3_b] <= r_yi;
        end else if (r_p3_op == fftc_pkg::OP_BIN) begin
            mem_re[r_p3_a] <= r_xr;
            mem_im[r_p3_a] <= r_xi;
        end
        r_ar <= mem_re[i_cmd.addr_a[AW-1:0]];
        r_ai <= mem_im[i_cmd.addr_a[AW-1:0]];
        r_br <= mem_re[i_cmd.addr_b[AW-1:0]];
        r_bi <= mem_im[i_cmd.addr_b[AW-1:0]];
        r_cr <= coef_re[i_cmd.addr_a[AW-1:0]];
        r_ci <= coef_im[i_cmd.addr_a[AW-1:0]];
        r_wr <= fftc_pkg::rom_cos(i_cmd.tw_idx);
        r_wi <= i_cmd.inverse ? -fftc_pkg::rom_sin(i_cmd.tw_idx)
                              : fftc_pkg::rom_sin(i_cmd.tw_idx);
        r_p1_a    <= i_cmd.addr_a[AW-1:0];
        r_p1_b    <= i_cmd.addr_b[AW-1:0];
        r_p1_bits <= i_cmd.bits;
        r_p1_last <= i_cmd.last;
    end

    // stage 2: four products (butterfly: b*w, bin: a*c)
    logic signed [WORK_BITS-1:0] m_x, m_y;
    logic signed [fftc_pkg::TW_BITS-1:0] m_c, m_s;
    always_comb begin
        if (r_p1_op == fftc_pkg::OP_BIN) begin
            m_x = r_ar; m_y = r_ai;
            m_c = fftc_pkg::TW_BITS'(r_cr); m_s = fftc_pkg::TW_BITS'(r_ci);
        end else begin
            m_x = r_br; m_y = r_bi; m_c = r_wr; m_s = r_wi;
        end
    end
    always_ff @(posedge i_clk) begin
        r_m0 <= m_x * m_c;
        r_m1 <= m_y * m_s;
        r_m2 <= m_y * m_c;
        r_m3 <= m_x * m_s;
        r2_ar <= r_ar;
        r2_ai <= r_ai;
        r2_br <= r_br;
        r2_bi <= r_bi;
        r_p2_a    <= r_p1_a;
        r_p2_b    <= r_p1_b;
        r_p2_bits <= r_p1_bits;
        r_p2_last <= r_p1_last;
    end

    // stage 3: round, butterfly add/sub, swap, or output scaling
    logic signed [SW-1:0] pr, pi, sr, si, dr, di, ov;
    logic signed [SW-1:0] rnd;
    logic [2:0] sh;
    logic signed [SW-1:0] lim;
    logic clip;
    logic signed [SAMPLE_BITS-1:0] outv;
    always_comb begin
        sh  = (r_p2_op == fftc_pkg::OP_BIN) ? 3'd0 : 3'd3; // extra shift relative to 12
        rnd = (r_p2_op == fftc_pkg::OP_BIN) ? SW'(1) <<< 11 : SW'(1) <<< 14;
        pr  = SW'(r_m0) - SW'(r_m1) + rnd;
        pi  = SW'(r_m2) + SW'(r_m3) + rnd;
        pr  = (pr >>> 12) >>> sh;
        pi  = (pi >>> 12) >>> sh;
        pr  = SW'(sat(pr));
        pi  = SW'(sat(pi));
        sr  = SW'(r2_ar) + pr;
        si  = SW'(r2_ai) + pi;
        dr  = SW'(r2_ar) - pr;
        di  = SW'(r2_ai) - pi;
        ov  = (SW'(r2_ar) + (SW'(1) <<< (r_p2_bits - 3'd1))) >>> r_p2_bits;
        lim = SW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        clip = 1'b0;
        if (ov > lim) begin
            outv = lim[SAMPLE_BITS-1:0]; clip = 1'b1;
        end else if (ov < -lim - SW'(1)) begin
            outv = SAMPLE_BITS'(-lim - SW'(1)); clip = 1'b1;
        end else begin
            outv = ov[SAMPLE_BITS-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        case (r_p2_op)
            fftc_pkg::OP_SWAP: begin
                // write b at a, a at b
                r_xr <= r2_br; r_xi <= r2_bi;
                r_yr <= r2_ar; r_yi <= r2_ai;
            end
            fftc_pkg::OP_BIN: begin
                r_xr <= pr[WORK_BITS-1:0]; r_xi <= pi[WORK_BITS-1:0];
                r_yr <= '0; r_yi <= '0;
            end
            default: begin
                r_xr <= sat(sr); r_xi <= sat(si);
                r_yr <= sat(dr); r_yi <= sat(di);
            end
        endcase
        r_p3_a     <= r_p2_a;
        r_p3_b     <= r_p2_b;
        o_res_data <= outv;
        o_res_clip <= clip;
        o_res_last <= r_p2_last;
    end

    assign o_res_valid = (r_p3_op == fftc_pkg::OP_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_op <= fftc_pkg::OP_NONE;
            r_p2_op <= fftc_pkg::OP_NONE;
            r_p3_op <= fftc_pkg::OP_NONE;
        end else begin
            r_p1_op <= (i_cmd.op == fftc_pkg::OP_LOAD) ? fftc_pkg::OP_NONE : i_cmd.op;
            r_p2_op <= r_p1_op;
            r_p3_op <= r_p2_op;
        end
    end
endmodule

[src/fftc_ofifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fftc_ofifo
// Small output queue between the datapath and the result channel.
// ----------------------------------------------------------------------------
module fftc_ofifo #(
    parameter int SAMPLE_BITS = fftc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic signed [SAMPLE_BITS-1:0] i_data,
    input  logic                          i_last,
    input  logic                          i_clip,
    output logic                          o_room,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_data,
    output logic                          o_last,
    output logic                          o_clip
);
    localparam int W = SAMPLE_BITS + 2;
    logic [W-1:0] r_q [2];
    logic r_rp, r_wp;
    logic [1:0] r_cnt;
    logic rd;

    assign o_valid = (r_cnt != 2'd0);
    assign rd      = o_valid && !i_stall;
    assign o_room  = (r_cnt == 2'd0);  // one entry queued ahead of the datapath at most
    assign {o_data, o_last, o_clip} = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_q[r_wp] <= {i_data, i_last, i_clip};
        if (!i_rst_n) begin
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_wr) - 2'(rd);
        end
    end
endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fft_circular_convolution: directed rows, then
// random blocks over several lengths, each checked against a fixed-point
// convolution model kept in the bench.
// ----------------------------------------------------------------------------
module tb;

    localparam int WB = 40;

    typedef struct {
        int          wr_cfg;   // -1: no register write before this row
        logic [15:0] smp;
        logic [15:0] rre;
        logic [15:0] rim;
        bit          typed;    // expected output known by inspection
        logic [15:0] t_out;
        bit          t_clip;
    } t_row;

    typedef struct {
        logic [15:0] smp;
        bit          last;
        bit          clip;
    } t_conv_out;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_cfg_we;
    logic [fftc_pkg::LOG_BITS-1:0]         i_cfg_wdata;
    logic                                  i_valid;
    logic                                  o_stall;
    logic signed [fftc_pkg::IN_BITS-1:0]   i_sample_in;
    logic signed [fftc_pkg::COEF_BITS-1:0] i_resp_real;
    logic signed [fftc_pkg::COEF_BITS-1:0] i_resp_imag;
    logic                                  o_valid;
    logic                                  i_stall;
    logic signed [15:0]                    o_sample_out;
    logic                                  o_is_last;
    logic                                  o_clipped;

    fft_circular_convolution i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample_in  (i_sample_in),
        .i_resp_real  (i_resp_real),
        .i_resp_imag  (i_resp_imag),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_out (o_sample_out),
        .o_is_last    (o_is_last),
        .o_clipped    (o_clipped)
    );

    // bench copy of block state
    logic [2:0]  len_reg;
    int          fill_cnt;
    longint      acc_re [64];
    longint      acc_im [64];
    longint      bin_re [64];
    longint      bin_im [64];
    bit          slot_typed [64];
    logic [15:0] slot_out [64];
    bit          slot_clip [64];

    t_conv_out   conv_q [$];
    int          errors;
    bit          send_gaps;
    bit          recv_gaps;
    int          gap_pct;

    const int qsine [17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                             25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767};

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("fft_circular_convolution verification failed");
        $finish;
    end

    task automatic report(input string msg);
        $display("%0t ERROR %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint sat40(input longint x);
        longint hi;
        hi = (longint'(1) <<< (WB - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    function automatic longint round_pair(input longint a, input longint wa, input longint b,
                                          input longint wb, input int s);
        longint acc;
        acc = a * wa + b * wb + (longint'(1) <<< (s - 1));
        return sat40(acc >>> s);
    endfunction

    function automatic int tw_sin(input int t);
        t = t & 31;
        return (t <= 16) ? qsine[t] : qsine[32 - t];
    endfunction

    function automatic int tw_cos(input int t);
        t = t & 31;
        return (t <= 16) ? qsine[16 - t] : -qsine[t - 16];
    endfunction

    function automatic int bitrev(input int v, input int nb);
        int r;
        r = 0;
        for (int i = 0; i < nb; i++) begin
            r = (r << 1) | ((v >> i) & 1);
        end
        return r;
    endfunction

    function automatic void fft_pass(input int n, input int nb, input bit inv);
        longint t, tr, ti, ar, ai;
        int     r, j, k, wr, wi;
        for (int i = 0; i < n; i++) begin
            r = bitrev(i, nb);
            if (i < r) begin
                t = acc_re[i]; acc_re[i] = acc_re[r]; acc_re[r] = t;
                t = acc_im[i]; acc_im[i] = acc_im[r]; acc_im[r] = t;
            end
        end
        for (int h = 1; h < n; h = h << 1) begin
            for (int i = 0; i < n; i += 2 * h) begin
                for (int m = 0; m < h; m++) begin
                    j  = i + m;
                    k  = j + h;
                    wr = tw_cos(m * (64 / (2 * h)));
                    wi = tw_sin(m * (64 / (2 * h)));
                    if (inv) wi = -wi;
                    tr = round_pair(acc_re[k], wr, acc_im[k], -wi, 15);
                    ti = round_pair(acc_im[k], wr, acc_re[k], wi, 15);
                    ar = acc_re[j];
                    ai = acc_im[j];
                    acc_re[k] = sat40(ar - tr);
                    acc_im[k] = sat40(ai - ti);
                    acc_re[j] = sat40(ar + tr);
                    acc_im[j] = sat40(ai + ti);
                end
            end
        end
    endfunction

    // one accepted request; queues the block's outputs once it is full
    function automatic void convolve_request(input t_row rq);
        int        nb, n;
        longint    xr, xi, v;
        t_conv_out o;
        nb = (len_reg < 1) ? 1 : (len_reg > 6) ? 6 : int'(len_reg);
        n  = 1 << nb;
        if (fill_cnt >= n) fill_cnt = 0;
        acc_re[fill_cnt]     = longint'($signed(rq.smp));
        acc_im[fill_cnt]     = 0;
        bin_re[fill_cnt]     = longint'($signed(rq.rre));
        bin_im[fill_cnt]     = longint'($signed(rq.rim));
        slot_typed[fill_cnt] = rq.typed;
        slot_out[fill_cnt]   = rq.t_out;
        slot_clip[fill_cnt]  = rq.t_clip;
        fill_cnt++;
        if (fill_cnt < n) return;
        fill_cnt = 0;
        fft_pass(n, nb, 1'b0);
        for (int i = 0; i < n; i++) begin
            xr = acc_re[i];
            xi = acc_im[i];
            acc_re[i] = round_pair(xr, bin_re[i], xi, -bin_im[i], 12);
            acc_im[i] = round_pair(xr, bin_im[i], xi, bin_re[i], 12);
        end
        fft_pass(n, nb, 1'b1);
        for (int i = 0; i < n; i++) begin
            v = (acc_re[i] + (longint'(1) <<< (nb - 1))) >>> nb;
            o.clip = (v > 32767 || v < -32768);
            o.smp  = (v > 32767) ? 16'h7fff : (v < -32768) ? 16'h8000 : v[15:0];
            o.last = (i == n - 1);
            if (slot_typed[i]) begin
                o.smp  = slot_out[i];
                o.clip = slot_clip[i];
            end
            conv_q.push_back(o);
        end
    endfunction

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (conv_q.size() != 0 && guard < 400_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_len(input int val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val[2:0];
        @(posedge i_clk);
        len_reg  = val[2:0];
        fill_cnt = 0;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(input t_row rq);
        if (send_gaps) begin
            while ($urandom_range(99) < gap_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_sample_in <= rq.smp;
        i_resp_real <= rq.rre;
        i_resp_imag <= rq.rim;
        do @(posedge i_clk); while (o_stall);
        convolve_request(rq);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_resp();
        case ($urandom_range(5))
            0: return pick16();
            1: return 16'h1000;
            default: return 16'($signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    // receiver side
    always @(posedge i_clk) begin
        i_stall <= recv_gaps && ($urandom_range(99) < gap_pct);
    end

    always @(posedge i_clk) begin
        t_conv_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (conv_q.size() == 0) begin
                report($sformatf("unexpected output %0d", o_sample_out));
            end else begin
                e = conv_q.pop_front();
                if (o_sample_out !== e.smp)
                    report($sformatf("sample_out %0d, want %0d", o_sample_out,
                                     $signed(e.smp)));
                if (o_is_last !== e.last)
                    report($sformatf("is_last %b, want %b", o_is_last, e.last));
                if (o_clipped !== e.clip)
                    report($sformatf("clipped %b, want %b", o_clipped, e.clip));
            end
        end
    end

    t_row dir_rows [21] = '{
        '{ 1, 16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 0},
        '{-1, 16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 0},
        '{-1, 16'h7fff, 16'h0000, 16'h0000, 1, 16'h0000, 0},
        '{-1, 16'h8000, 16'h0000, 16'h0000, 1, 16'h0000, 0},
        '{-1, 16'h7fff, 16'h7fff, 16'h7fff, 0, 16'h0000, 0},
        '{-1, 16'h8000, 16'h8000, 16'h8000, 0, 16'h0000, 0},
        '{-1, 16'h7fff, 16'h8000, 16'h7fff, 0, 16'h0000, 0},
        '{-1, 16'h8000, 16'h7fff, 16'h8000, 0, 16'h0000, 0},
        '{-1, 16'h8000, 16'h8000, 16'h0000, 0, 16'h0000, 0},
        '{-1, 16'h8000, 16'h8000, 16'h0000, 0, 16'h0000, 0},
        '{-1, 16'h0001, 16'h1000, 16'h0000, 0, 16'h0000, 0},
        '{-1, 16'hffff, 16'h1000, 16'h0000, 0, 16'h0000, 0},
        '{-1, 16'h0064, 16'h0000, 16'h1000, 0, 16'h0000, 0},
        '{-1, 16'hfff9, 16'hf000, 16'h0000, 0, 16'h0000, 0},
        // restart: one sample loaded, then the length is rewritten
        '{ 2, 16'h1234, 16'h1000, 16'h0000, 0, 16'h0000, 0},
        '{ 2, 16'h4000, 16'h1000, 16'h0000, 0, 16'h0000, 0},
        '{-1, 16'hc000, 16'h0800, 16'h0800, 0, 16'h0000, 0},
        '{-1, 16'h2000, 16'hf800, 16'h0400, 0, 16'h0000, 0},
        '{-1, 16'h8000, 16'h7fff, 16'h0000, 0, 16'h0000, 0},
        // length codes outside 1..6 clamp
        '{ 0, 16'h5555, 16'h1000, 16'h0000, 0, 16'h0000, 0},
        '{-1, 16'haaaa, 16'h0000, 16'h1000, 0, 16'h0000, 0}
    };

    int ph_len   [10] = '{-1, 0, 3, 2, 1, 5, 7, 4, 3, 2};
    int ph_count [10] = '{64, 40, 48, 48, 40, 64, 64, 48, 32, 32};

    initial begin
        t_row rq;
        int   extra;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_sample_in = '0;
        i_resp_real = '0;
        i_resp_imag = '0;
        i_stall     = 1'b0;
        send_gaps   = 1'b0;
        recv_gaps   = 1'b0;
        gap_pct     = 74;
        errors      = 0;
        len_reg     = 3'(fftc_pkg::LOG_RESET);
        fill_cnt    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].wr_cfg >= 0) begin
                i_valid <= 1'b0;
                write_len(dir_rows[r].wr_cfg);
            end
            send_request(dir_rows[r]);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        for (int p = 0; p < 10; p++) begin
            if (ph_len[p] >= 0) begin
                i_valid <= 1'b0;
                write_len(ph_len[p]);
            end
            send_gaps = (p % 4 == 1) || (p % 4 == 3);
            recv_gaps = (p % 4 == 2) || (p % 4 == 3);
            gap_pct   = (p % 4 == 3) ? 25 : 74;
            // odd phases may leave a partial block for the next write to drop
            extra = (p % 2) ? $urandom_range(3) : 0;
            for (int k = 0; k < ph_count[p] + extra; k++) begin
                rq.wr_cfg = -1;
                rq.smp    = pick16();
                rq.rre    = pick_resp();
                rq.rim    = pick_resp();
                rq.typed  = 1'b0;
                rq.t_out  = '0;
                rq.t_clip = 1'b0;
                send_request(rq);
            end
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        wait_idle();

        if (conv_q.size() != 0)
            report($sformatf("%0d outputs never arrived", conv_q.size()));
        if (errors == 0) begin
            $display("fft_circular_convolution verification clean");
        end else begin
            $display("fft_circular_convolution verification failed");
        end
        $finish;
    end

endmodule
